FILE: hdl/window_coefficient_generator_assert.svh
// Assertion shorthands shared by the RTL. Each expects clk and arst_n in scope.
`ifndef WINDOW_COEFFICIENT_GENERATOR_ASSERT_SVH
`define WINDOW_COEFFICIENT_GENERATOR_ASSERT_SVH

// Same-cycle implication, quiet while reset is active.
`define WCG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet while reset is active.
`define WCG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/wcg_pkg.sv
package wcg_pkg;

	localparam int IDX_W      = 12;
	localparam int LEN_W      = 13;
	localparam int KIND_W     = 3;
	localparam int COEF_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	localparam int MAX_LENGTH_DEF = 4096;
	localparam logic [LEN_W-1:0] LENGTH_RESET = 13'd1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LENGTH = 1'b0,
		REG_KIND   = 1'b1
	} reg_idx_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_HANN       = 3'd0,
		KIND_ROOT_HANN  = 3'd1,
		KIND_QROOT_HANN = 3'd2,
		KIND_BLACKMAN   = 3'd3,
		KIND_TRIANGLE   = 3'd4
	} kind_t;

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [31:0] PI_Q30  = 32'd3373259426;
	localparam logic [28:0] BK_LIN  = 29'd386547057;
	localparam logic [29:0] BK_SQ   = 30'd687194767;
	localparam logic [COEF_W-1:0] COEF_ONE = 16'h8000;

	// Taylor series of sin, innermost term first
	localparam int HORNER_STEPS = 5;
	localparam logic [6:0] HORNER_DEN [HORNER_STEPS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
	localparam logic [29:0] HORNER_RECIP [HORNER_STEPS] = '{
		30'((64'd1 << 32) / 110),
		30'((64'd1 << 32) / 72),
		30'((64'd1 << 32) / 42),
		30'((64'd1 << 32) / 20),
		30'((64'd1 << 32) / 6)
	};

	typedef struct packed {
		logic              in_range;
		logic [43:0]       pq;    // phase dividend in, quotient out
		logic [LEN_W-1:0]  prem;
		logic [31:0]       tq;    // triangle dividend in, quotient out
		logic [LEN_W-1:0]  trem;
	} div_t;

	typedef struct packed {
		logic [LEN_W-1:0] rem;
		logic [3:0]       q;
	} div4_t;

	typedef struct packed {
		logic [63:0] rad;
		logic [31:0] rem;
		logic [31:0] root;
	} sq_t;

	typedef struct packed {
		logic              in_range;
		logic [COEF_W-1:0] tri_coef;
	} tag_t;

	// four restoring division steps
	function automatic div4_t div4(input logic [LEN_W-1:0] dvsr,
			input logic [LEN_W-1:0] rem_in, input logic [3:0] bits);
		logic [LEN_W:0] r;
		div4_t res;
		r = {1'b0, rem_in};
		res.q = '0;
		for (int b = 3; b >= 0; b--) begin
			r = {r[LEN_W-1:0], bits[b]};
			if (r >= {1'b0, dvsr}) begin
				r = r - {1'b0, dvsr};
				res.q[b] = 1'b1;
			end
		end
		res.rem = r[LEN_W-1:0];
		return res;
	endfunction

	// four digit-by-digit square root steps, two radicand bits each
	function automatic sq_t sqrt4(input sq_t a);
		logic [33:0] r;
		logic [33:0] tr;
		sq_t o;
		o = a;
		for (int b = 0; b < 4; b++) begin
			r = {o.rem, o.rad[63:62]};
			tr = {o.root, 2'b01};
			if (r >= tr) begin
				r = r - tr;
				o.root = {o.root[30:0], 1'b1};
			end else begin
				o.root = {o.root[30:0], 1'b0};
			end
			o.rem = r[31:0];
			o.rad = {o.rad[61:0], 2'b00};
		end
		return o;
	endfunction

	// Q30 to Q1.15, round half up, saturate at one
	function automatic logic [COEF_W-1:0] to_q15(input logic [31:0] v);
		logic [32:0] r;
		r = ({1'b0, v} + 33'd16384) >> 15;
		return (r > 33'(COEF_ONE)) ? COEF_ONE : r[COEF_W-1:0];
	endfunction

endpackage

FILE: hdl/window_coefficient_generator.sv
// Window coefficient generator: returns one unsigned Q1.15 coefficient per sample index for a
// Hann, root Hann, fourth-root Hann, Blackman or triangular window of programmable length.
// Fully pipelined: one index per clock while out_ready is high, through 44 register stages.
// Most of the stages go to the phase division i/(L-1) (eleven stages, four quotient bits
// each), the Horner sine series (three stages per term) and the square root (eight stages).
// A stall reaches back through a combinational ready chain only as far as the first empty
// stage, so bubbles are squeezed out and the input keeps taking beats while a result waits
// until the pipeline is full. Write window_length and window_kind only while the pipeline
// is empty. No start-up sweep: the block takes beats right after reset.
`include "window_coefficient_generator_assert.svh"

module window_coefficient_generator #(
	parameter int MAX_LENGTH = wcg_pkg::MAX_LENGTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [wcg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wcg_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [wcg_pkg::IDX_W-1:0]        sample_index,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [wcg_pkg::COEF_W-1:0]       coefficient,
	output logic                             index_in_range
);

	localparam int ST_PREP     = 1;
	localparam int ST_DIV_LAST = 12;
	localparam int ST_TRI_LAST = 9;
	localparam int ST_FOLD     = 13;
	localparam int ST_ZP       = 14;
	localparam int ST_Z        = 15;
	localparam int ST_ZZ       = 16;
	localparam int ST_H0       = 17;
	localparam int ST_H_LAST   = ST_H0 + 3 * wcg_pkg::HORNER_STEPS - 1;
	localparam int ST_SM       = ST_H_LAST + 1;
	localparam int ST_S        = ST_SM + 1;
	localparam int ST_SS       = ST_S + 1;
	localparam int ST_HN       = ST_SS + 1;
	localparam int ST_T0       = ST_HN + 1;
	localparam int ST_BK       = ST_T0 + 2;
	localparam int ST_T_LAST   = ST_T0 + 7;
	localparam int NS          = ST_T_LAST + 1;

	localparam int LW = wcg_pkg::LEN_W;

	logic [LW-1:0]               window_length_q;
	logic [wcg_pkg::KIND_W-1:0]  window_kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= wcg_pkg::LENGTH_RESET;
			window_kind_q   <= wcg_pkg::KIND_HANN;
		end else if (cfg_write) begin
			unique case (wcg_pkg::reg_idx_t'(cfg_index))
				wcg_pkg::REG_LENGTH: window_length_q <= cfg_data[LW-1:0];
				wcg_pkg::REG_KIND:   window_kind_q   <= cfg_data[wcg_pkg::KIND_W-1:0];
			endcase
		end
	end

	// the user must keep config stable while items are in flight (the block does not enforce it); stages read it directly
	logic [LW-1:0] len_eff;
	logic [LW-1:0] dvsr;
	logic          len_ge2;

	assign len_eff = (32'(window_length_q) < 32'(MAX_LENGTH)) ? window_length_q
		: LW'(MAX_LENGTH);
	assign dvsr    = len_eff - LW'(1);
	assign len_ge2 = (len_eff >= LW'(2));

	// stage valids and per-stage advance
	logic [NS:1]   stage_valid_q;
	logic [NS+1:1] en;
	logic [NS:1]   valid_in;

	always_comb begin
		en[NS+1] = out_ready;
		for (int k = NS; k >= 1; k--) begin
			en[k] = !stage_valid_q[k] || en[k+1];
		end
	end

	assign valid_in = {stage_valid_q[NS-1:1], in_valid};
	assign in_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (en[k]) stage_valid_q[k] <= valid_in[k];
			end
		end
	end

	// prepare both dividends
	wcg_pkg::div_t div_s [ST_PREP:ST_DIV_LAST];
	wcg_pkg::div_t prep;
	logic [LW-1:0] two_i;
	logic [LW-1:0] tri_gap;
	logic [LW-1:0] num;

	always_comb begin
		two_i   = {sample_index, 1'b0};
		tri_gap = (two_i >= len_eff) ? two_i - len_eff : len_eff - two_i;
		num     = len_eff - tri_gap;
		prep.in_range = (LW'(sample_index) < len_eff);
		prep.pq       = {sample_index, 32'(dvsr >> 1)};
		prep.prem     = '0;
		prep.tq       = 32'({num, 15'b0}) + 32'(len_eff >> 1);
		prep.trem     = '0;
	end

	always_ff @(posedge clk) begin
		if (en[ST_PREP]) div_s[ST_PREP] <= prep;
	end

	for (genvar j = ST_PREP + 1; j <= ST_DIV_LAST; j++) begin : g_div
		wcg_pkg::div4_t pd;
		wcg_pkg::div4_t td;
		wcg_pkg::div_t  nx;
		always_comb begin
			pd = wcg_pkg::div4(dvsr, div_s[j-1].prem, div_s[j-1].pq[43:40]);
			td = wcg_pkg::div4(len_eff, div_s[j-1].trem, div_s[j-1].tq[31:28]);
			nx = div_s[j-1];
			nx.pq   = {div_s[j-1].pq[39:0], pd.q};
			nx.prem = pd.rem;
			if (j <= ST_TRI_LAST) begin
				nx.tq   = {div_s[j-1].tq[27:0], td.q};
				nx.trem = td.rem;
			end
		end
		always_ff @(posedge clk) begin
			if (en[j]) div_s[j] <= nx;
		end
	end

	// fold the phase to the rising half
	wcg_pkg::tag_t tag_s [ST_FOLD:NS-1];
	logic [31:0]   y_s13;
	logic [32:0]   xq;
	logic [31:0]   y_next;
	wcg_pkg::tag_t tag_next;

	always_comb begin
		xq = div_s[ST_DIV_LAST].pq[32:0];
		if (!len_ge2) begin
			xq = '0;
		end else if (div_s[ST_DIV_LAST].pq[43:32] != '0 && xq != 33'h1_0000_0000) begin
			xq = 33'h1_0000_0000;
		end
		y_next = (xq <= 33'h0_8000_0000) ? xq[31:0] : 32'(33'h1_0000_0000 - xq);
		tag_next.in_range = div_s[ST_DIV_LAST].in_range;
		tag_next.tri_coef = (div_s[ST_DIV_LAST].tq > 32'(wcg_pkg::COEF_ONE))
			? wcg_pkg::COEF_ONE : div_s[ST_DIV_LAST].tq[15:0];
	end

	always_ff @(posedge clk) begin
		if (en[ST_FOLD]) begin
			y_s13          <= y_next;
			tag_s[ST_FOLD] <= tag_next;
		end
	end

	for (genvar j = ST_FOLD + 1; j < NS; j++) begin : g_tag
		always_ff @(posedge clk) begin
			if (en[j]) tag_s[j] <= tag_s[j-1];
		end
	end

	// z = y * pi, then z squared
	logic [63:0] zp_s14;
	logic [30:0] z_s  [ST_Z:ST_H_LAST];
	logic [31:0] z2_s [ST_ZZ:ST_H_LAST];
	logic [63:0] zp_round;
	logic [61:0] zz;

	assign zp_round = zp_s14 + 64'h8000_0000;
	assign zz       = 62'(z_s[ST_Z]) * 62'(z_s[ST_Z]);

	always_ff @(posedge clk) begin
		if (en[ST_ZP]) zp_s14 <= 64'(y_s13) * 64'(wcg_pkg::PI_Q30);
		if (en[ST_Z]) z_s[ST_Z] <= zp_round[62:32];
		if (en[ST_ZZ]) begin
			z_s[ST_ZZ]  <= z_s[ST_Z];
			z2_s[ST_ZZ] <= zz[61:30];
		end
	end

	for (genvar j = ST_ZZ + 1; j <= ST_H_LAST; j++) begin : g_zcarry
		always_ff @(posedge clk) begin
			if (en[j]) begin
				z_s[j]  <= z_s[j-1];
				z2_s[j] <= z2_s[j-1];
			end
		end
	end

	// Horner sine series: multiply, reciprocal, correct
	logic [62:0] m_s  [wcg_pkg::HORNER_STEPS];
	logic [31:0] p_s  [wcg_pkg::HORNER_STEPS];
	logic [61:0] pm_s [wcg_pkg::HORNER_STEPS];
	logic [30:0] t_s  [wcg_pkg::HORNER_STEPS];

	for (genvar k = 0; k < wcg_pkg::HORNER_STEPS; k++) begin : g_horner
		localparam int SA = ST_H0 + 3 * k;
		logic [30:0] t_in;
		logic [29:0] q0;
		logic [37:0] r;
		logic [30:0] q;

		if (k == 0) begin : g_first
			assign t_in = wcg_pkg::ONE_Q30;
		end else begin : g_next
			assign t_in = t_s[k-1];
		end

		always_comb begin
			q0 = pm_s[k][61:32];
			r  = 38'(p_s[k]) - 38'(q0) * 38'(wcg_pkg::HORNER_DEN[k]);
			// the reciprocal estimate is short by at most one
			q  = (r >= 38'(wcg_pkg::HORNER_DEN[k])) ? 31'(q0) + 31'd1 : 31'(q0);
		end

		always_ff @(posedge clk) begin
			if (en[SA]) m_s[k] <= 63'(z2_s[SA-1]) * 63'(t_in);
			if (en[SA+1]) begin
				p_s[k]  <= m_s[k][61:30];
				pm_s[k] <= 62'(m_s[k][61:30]) * 62'(wcg_pkg::HORNER_RECIP[k]);
			end
			if (en[SA+2]) t_s[k] <= wcg_pkg::ONE_Q30 - q;
		end
	end

	// sine, then Hann
	logic [61:0] sm_s32;
	logic [61:0] ss_s34;
	logic [30:0] s_s [ST_S:ST_T_LAST];
	logic [30:0] h_s [ST_HN:ST_T_LAST];
	logic [61:0] ss_round;

	assign ss_round = ss_s34 + (62'd1 << 29);

	always_ff @(posedge clk) begin
		if (en[ST_SM]) sm_s32 <= 62'(z_s[ST_H_LAST]) * 62'(t_s[wcg_pkg::HORNER_STEPS-1]);
		if (en[ST_S]) begin
			s_s[ST_S] <= (sm_s32[61:30] > 32'(wcg_pkg::ONE_Q30)) ? wcg_pkg::ONE_Q30
				: sm_s32[60:30];
		end
		if (en[ST_SS]) begin
			ss_s34     <= 62'(s_s[ST_S]) * 62'(s_s[ST_S]);
			s_s[ST_SS] <= s_s[ST_S];
		end
		if (en[ST_HN]) begin
			h_s[ST_HN] <= ss_round[60:30];
			s_s[ST_HN] <= s_s[ST_SS];
		end
	end

	for (genvar j = ST_T0; j <= ST_T_LAST; j++) begin : g_scarry
		always_ff @(posedge clk) begin
			if (en[j]) begin
				s_s[j] <= s_s[j-1];
				h_s[j] <= h_s[j-1];
			end
		end
	end

	// Blackman = 0.36h + 0.64h^2
	logic [61:0] hh_s36;
	logic [59:0] bl_s37;
	logic [60:0] bq_s37;
	logic [31:0] bk_s [ST_BK:ST_T_LAST];
	logic [61:0] bk_sum;

	assign bk_sum = 62'(bl_s37) + 62'(bq_s37) + (62'd1 << 29);

	always_ff @(posedge clk) begin
		if (en[ST_T0]) hh_s36 <= 62'(h_s[ST_HN]) * 62'(h_s[ST_HN]);
		if (en[ST_T0+1]) begin
			bl_s37 <= 60'(wcg_pkg::BK_LIN) * 60'(h_s[ST_T0]);
			bq_s37 <= 61'(wcg_pkg::BK_SQ) * 61'(hh_s36[61:30]);
		end
		if (en[ST_BK]) bk_s[ST_BK] <= bk_sum[61:30];
	end

	for (genvar j = ST_BK + 1; j <= ST_T_LAST; j++) begin : g_bkcarry
		always_ff @(posedge clk) begin
			if (en[j]) bk_s[j] <= bk_s[j-1];
		end
	end

	// fourth root = sqrt(s * 2^30)
	wcg_pkg::sq_t sq_s [ST_T0:ST_T_LAST];
	wcg_pkg::sq_t sq_init;

	always_comb begin
		sq_init.rad  = {3'b000, s_s[ST_HN], 30'b0};
		sq_init.rem  = '0;
		sq_init.root = '0;
	end

	for (genvar j = ST_T0; j <= ST_T_LAST; j++) begin : g_sqrt
		if (j == ST_T0) begin : g_head
			always_ff @(posedge clk) begin
				if (en[j]) sq_s[j] <= wcg_pkg::sqrt4(sq_init);
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (en[j]) sq_s[j] <= wcg_pkg::sqrt4(sq_s[j-1]);
			end
		end
	end

	// pick the kind and drive the output register
	logic [wcg_pkg::COEF_W-1:0] coef_s44;
	logic                       range_s44;
	logic [wcg_pkg::COEF_W-1:0] coef_next;

	always_comb begin
		unique case (wcg_pkg::kind_t'(window_kind_q))
			wcg_pkg::KIND_HANN:       coef_next = wcg_pkg::to_q15(32'(h_s[ST_T_LAST]));
			wcg_pkg::KIND_ROOT_HANN:  coef_next = wcg_pkg::to_q15(32'(s_s[ST_T_LAST]));
			wcg_pkg::KIND_QROOT_HANN: coef_next = wcg_pkg::to_q15(sq_s[ST_T_LAST].root);
			wcg_pkg::KIND_BLACKMAN:   coef_next = wcg_pkg::to_q15(bk_s[ST_T_LAST]);
			wcg_pkg::KIND_TRIANGLE:   coef_next = tag_s[NS-1].tri_coef;
			default:                  coef_next = '0;
		endcase
		if (!tag_s[NS-1].in_range) coef_next = '0;
	end

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			coef_s44  <= coef_next;
			range_s44 <= tag_s[NS-1].in_range;
		end
	end

	assign out_valid      = stage_valid_q[NS];
	assign coefficient    = coef_s44;
	assign index_in_range = range_s44;

	`WCG_ASSERT_NOW(a_out_of_range_zero, out_valid && !index_in_range, coefficient == '0, "out-of-range index gave a nonzero coefficient")
	`WCG_ASSERT_NOW(a_coef_max, out_valid, coefficient <= wcg_pkg::COEF_ONE, "coefficient above one")
	`WCG_ASSERT_NOW(a_empty_out_ready, !out_valid, in_ready, "input stalled with empty output")
	`WCG_ASSERT_NOW(a_unused_kind_zero, out_valid && (window_kind_q > wcg_pkg::KIND_TRIANGLE), coefficient == '0, "unused kind gave a nonzero coefficient")
	`WCG_ASSERT_NEXT(a_stall_keeps_result, out_valid && !out_ready, out_valid, "stalled result dropped")

endmodule
